[hdl/brp_pkg.sv]
// shared constants, types and the lowest-set-bit encoder for the recycle pool
`default_nettype none
package brp_pkg;

	localparam int POOL_SLOTS  = 64;
	localparam int HANDLE_BITS = 32;
	localparam int SLOT_BITS   = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int SLOT_W      = 6;
	localparam int COUNT_W     = 32;

	typedef enum logic {
		MODE_ALLOC   = 1'b0,
		MODE_RELEASE = 1'b1
	} mode_t;

	typedef logic [POOL_SLOTS-1:0] slot_mask_t;
	typedef logic [SLOT_BITS-1:0]  slot_idx_t;

	typedef struct packed {
		logic      hit;
		slot_idx_t slot;
	} pick_t;

	// isolate the lowest set bit, then encode the one-hot word
	function automatic slot_idx_t lowest_idx(input slot_mask_t v);
		slot_mask_t iso;
		slot_idx_t  idx;
		iso = v & (~v + slot_mask_t'(1));
		idx = '0;
		for (int i = 0; i < POOL_SLOTS; i++) begin
			if (iso[i]) begin
				idx = idx | slot_idx_t'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

[hdl/brp_slot_pick.sv]
// slot picker: lowest occupied slot on allocate, lowest free slot on release
`default_nettype none
module brp_slot_pick
	import brp_pkg::*;
(
	input  wire mode_t      mode,
	input  wire slot_mask_t occ,
	output pick_t           pick
);

	slot_mask_t search;

	always_comb begin
		case (mode)
			MODE_ALLOC:   search = occ;
			MODE_RELEASE: search = ~occ;
			default:      search = occ;
		endcase
		pick.hit  = |search;
		pick.slot = lowest_idx(search);
	end

endmodule
`default_nettype wire

[hdl/bitmap_recycle_pool.sv]
// bitmap_recycle_pool: recycle pool of freed buffer handles with occupancy bitmap
//
// requests arrive on req_valid/req_ready with mode and release_handle; each request
// gives exactly one response beat on rsp_valid/rsp_ready.
// mode 0 allocates: the handle in the lowest occupied slot comes back with
// from_pool set, or from_pool stays low when the pool is empty.
// mode 1 releases: the handle goes to the lowest free slot, or dropped is set
// when every slot is full.
// in_use and peak_in_use report the counts after the request.
// a request beat passes one input register, then the picker and handle memory
// read into the response register.
// throughput is one request per cycle while the receiver does not stall; the loop
// that sets it is the occupancy bitmap, picked and updated in the same cycle.
// when the receiver stalls, the response register holds and req_ready drops
// once the input register is also full.
// reset empties the pool and clears both counts; handle storage is not cleared
// since a slot is only read after it has been written.
`default_nettype none
module bitmap_recycle_pool
	import brp_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	output logic                   req_ready,
	input  wire                    mode,
	input  wire  [31:0]            release_handle,
	output logic                   rsp_valid,
	input  wire                    rsp_ready,
	output logic [31:0]            handle_out,
	output logic                   from_pool,
	output logic [SLOT_W-1:0]      slot_used,
	output logic                   dropped,
	output logic [COUNT_W-1:0]     in_use,
	output logic [COUNT_W-1:0]     peak_in_use
);

	logic                   valid_s1;
	mode_t                  mode_s1;
	logic [HANDLE_BITS-1:0] handle_s1;

	logic                   valid_s2;
	logic                   from_pool_s2;
	slot_idx_t              slot_s2;
	logic                   dropped_s2;

	slot_mask_t             occ_q;
	logic [COUNT_W-1:0]     in_use_q;
	logic [COUNT_W-1:0]     peak_q;

	logic [HANDLE_BITS-1:0] handle_mem [POOL_SLOTS];
	logic [HANDLE_BITS-1:0] rd_data_q;

	pick_t                  pick;
	logic                   adv_s1;
	logic                   is_alloc;
	logic [COUNT_W-1:0]     in_use_nxt;
	logic [COUNT_W-1:0]     peak_nxt;
	slot_mask_t             slot_bit;

	brp_slot_pick u_pick (
		.mode (mode_s1),
		.occ  (occ_q),
		.pick (pick)
	);

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || adv_s1;
	assign is_alloc  = (mode_s1 == MODE_ALLOC);
	assign slot_bit  = slot_mask_t'(1) << pick.slot;

	always_comb begin
		in_use_nxt = in_use_q;
		peak_nxt   = peak_q;
		if (is_alloc) begin
			if (in_use_q != '1) begin
				in_use_nxt = in_use_q + COUNT_W'(1);
			end
			if (in_use_nxt > peak_q) begin
				peak_nxt = in_use_nxt;
			end
		end else if (in_use_q != '0) begin
			in_use_nxt = in_use_q - COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			mode_s1   <= mode_t'(mode);
			handle_s1 <= HANDLE_BITS'(release_handle);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			occ_q    <= '0;
			in_use_q <= '0;
			peak_q   <= '0;
		end else begin
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s1) begin
				in_use_q <= in_use_nxt;
				peak_q   <= peak_nxt;
				if (pick.hit) begin
					if (is_alloc) begin
						occ_q <= occ_q & ~slot_bit;
					end else begin
						occ_q <= occ_q | slot_bit;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			from_pool_s2 <= is_alloc && pick.hit;
			dropped_s2   <= !is_alloc && !pick.hit;
			slot_s2      <= pick.hit ? pick.slot : '0;
		end
	end

	// handle memory: written on a release that finds a free slot, read into a register on an allocate that hits
	always_ff @(posedge clk) begin
		if (adv_s1 && !is_alloc && pick.hit) begin
			handle_mem[pick.slot] <= handle_s1;
		end
		if (adv_s1 && is_alloc && pick.hit) begin
			rd_data_q <= handle_mem[pick.slot];
		end
	end

	assign rsp_valid   = valid_s2;
	assign handle_out  = from_pool_s2 ? 32'(rd_data_q) : 32'd0;
	assign from_pool   = from_pool_s2;
	assign slot_used   = SLOT_W'(slot_s2);
	assign dropped     = dropped_s2;
	assign in_use      = in_use_q;
	assign peak_in_use = peak_q;

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the bitmap recycle pool with its own response predictor
`timescale 1ns / 100ps
module tb_top
	import brp_pkg::*;
();

	localparam int QUIET_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CALM_ITEMS   = 200;
	localparam logic [63:0] HANDLE_KEEP =
		(HANDLE_BITS >= 64) ? '1 : ((64'd1 << HANDLE_BITS) - 64'd1);

	typedef struct {
		logic [31:0]        handle;
		logic               from_pool;
		logic [SLOT_W-1:0]  slot;
		logic               dropped;
		logic [COUNT_W-1:0] in_use;
		logic [COUNT_W-1:0] peak;
	} pool_rsp_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	mode_t              req_mode;
	logic [31:0]        req_handle;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic [31:0]        handle_out;
	logic               from_pool;
	logic [SLOT_W-1:0]  slot_used;
	logic               dropped;
	logic [COUNT_W-1:0] in_use;
	logic [COUNT_W-1:0] peak_in_use;

	// predicted pool contents and counts
	slot_mask_t         held_slots = '0;
	logic [31:0]        held_handle [POOL_SLOTS];
	logic [COUNT_W-1:0] live_count = '0;
	logic [COUNT_W-1:0] peak_count = '0;

	pool_rsp_t awaited_results[$];
	pool_rsp_t rsp_want;
	bit        idle_on = 1'b1;
	int        stall_left = 0;
	int        quiet_cycles = 0;
	int        mismatches = 0;
	int        n_alloc = 0;
	int        n_release = 0;
	int        n_recycled = 0;
	int        n_dropped = 0;
	int        n_empty = 0;

	bitmap_recycle_pool dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.mode           (req_mode),
		.release_handle (req_handle),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.handle_out     (handle_out),
		.from_pool      (from_pool),
		.slot_used      (slot_used),
		.dropped        (dropped),
		.in_use         (in_use),
		.peak_in_use    (peak_in_use)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// advance the predicted pool by one request and return its response
	function automatic pool_rsp_t serve_request(input mode_t m, input logic [31:0] h);
		pool_rsp_t r;
		int pick;
		r.handle    = '0;
		r.from_pool = 1'b0;
		r.slot      = '0;
		r.dropped   = 1'b0;
		pick = -1;
		if (m == MODE_ALLOC) begin
			for (int i = POOL_SLOTS - 1; i >= 0; i--)
				if (held_slots[i]) pick = i;
			if (pick >= 0) begin
				r.handle         = held_handle[pick];
				r.from_pool      = 1'b1;
				r.slot           = SLOT_W'(pick);
				held_slots[pick] = 1'b0;
			end
			if (live_count != '1) live_count++;
			if (live_count > peak_count) peak_count = live_count;
		end else begin
			if (live_count != '0) live_count--;
			for (int i = POOL_SLOTS - 1; i >= 0; i--)
				if (!held_slots[i]) pick = i;
			if (pick >= 0) begin
				held_handle[pick] = h & HANDLE_KEEP[31:0];
				held_slots[pick]  = 1'b1;
				r.slot            = SLOT_W'(pick);
			end else begin
				r.dropped = 1'b1;
			end
		end
		r.in_use = live_count;
		r.peak   = peak_count;
		return r;
	endfunction

	function automatic logic [31:0] rand_handle();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(input mode_t m, input logic [31:0] h);
		pool_rsp_t r;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		req_valid  = 1'b1;
		req_mode   = m;
		req_handle = h;
		do @(posedge clk); while (!req_ready);
		r = serve_request(m, h);
		awaited_results.push_back(r);
		if (m == MODE_ALLOC) begin
			n_alloc++;
			if (r.from_pool) n_recycled++;
			else n_empty++;
		end else begin
			n_release++;
			if (r.dropped) n_dropped++;
		end
	endtask

	// hold off the sender until every response is back
	task automatic drain_results();
		@(negedge clk);
		req_valid = 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_basic_requests();
		send_request(MODE_RELEASE, 32'h0000_0000);   // count at zero stays at zero
		send_request(MODE_ALLOC, 32'hFFFF_FFFF);     // handle input ignored on allocate
		send_request(MODE_ALLOC, 32'h0000_0000);     // empty pool, count still rises
		send_request(MODE_ALLOC, 32'h0000_0000);
		send_request(MODE_RELEASE, 32'hFFFF_FFFF);
		send_request(MODE_RELEASE, 32'hAAAA_AAAA);
		send_request(MODE_RELEASE, 32'h5555_5555);
		send_request(MODE_RELEASE, 32'h8000_0000);
		send_request(MODE_RELEASE, 32'h0000_0001);
		send_request(MODE_ALLOC, 32'h0000_0000);
		send_request(MODE_ALLOC, 32'h0000_0000);
		send_request(MODE_RELEASE, 32'h1234_5678);   // refills the lowest hole
		repeat (5) send_request(MODE_ALLOC, 32'h0000_0000);
	endtask

	task automatic test_fill_and_drop();
		while (held_slots != '1) send_request(MODE_RELEASE, rand_handle());
		repeat (3) send_request(MODE_RELEASE, rand_handle());
		while (held_slots != '0) send_request(MODE_ALLOC, $urandom);
		repeat (2) send_request(MODE_ALLOC, $urandom);
	endtask

	// segments lean toward release, allocate or neither so occupancy sweeps its range
	task automatic test_random_traffic(input int items, input bit allow_idle);
		int sent;
		int seg_len;
		int release_pct;
		sent = 0;
		while (sent < items) begin
			seg_len = $urandom_range(8, 80);
			case ($urandom_range(0, 2))
				0: release_pct = 15;
				1: release_pct = 50;
				default: release_pct = 85;
			endcase
			idle_on = allow_idle && ($urandom_range(0, 3) != 0);
			for (int k = 0; k < seg_len && sent < items; k++) begin
				if ($urandom_range(1, 100) <= release_pct)
					send_request(MODE_RELEASE, rand_handle());
				else
					send_request(MODE_ALLOC, $urandom);
				sent++;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// receiver stalls in bursts of random length while idle_on is set
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready = 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 4);
			rsp_ready  = 1'b0;
		end else begin
			rsp_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_results.size() == 0) begin
				$error("response beat with no request outstanding");
				mismatches++;
			end else begin
				rsp_want = awaited_results.pop_front();
				check_field("handle_out", rsp_want.handle, handle_out);
				check_field("from_pool", 32'(rsp_want.from_pool), 32'(from_pool));
				check_field("slot_used", 32'(rsp_want.slot), 32'(slot_used));
				check_field("dropped", 32'(rsp_want.dropped), 32'(dropped));
				check_field("in_use", rsp_want.in_use, in_use);
				check_field("peak_in_use", rsp_want.peak, peak_in_use);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req_mode   = MODE_ALLOC;
		req_handle = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_basic_requests();
		drain_results();
		test_fill_and_drop();
		drain_results();
		test_random_traffic(RANDOM_ITEMS / 2, 1'b1);
		drain_results();
		test_random_traffic(RANDOM_ITEMS / 2, 1'b1);
		test_random_traffic(CALM_ITEMS, 1'b0);
		drain_results();
		repeat (10) @(posedge clk);

		$display("requests: %0d allocates (%0d recycled, %0d from an empty pool), %0d releases",
			n_alloc, n_recycled, n_empty, n_release);
		$display("releases dropped on a full pool: %0d, final peak in use: %0d",
			n_dropped, peak_count);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
hdl/brp_pkg.sv
hdl/brp_slot_pick.sv
hdl/bitmap_recycle_pool.sv
tb/sv/tb_top.sv
